@@ rtl/nonuniform_table_interpolator_macros.svh @@
// Assertion macros for the nonuniform table interpolator.
`ifndef NONUNIFORM_TABLE_INTERPOLATOR_MACROS_SVH
`define NONUNIFORM_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define NTI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/nti_pkg.sv @@
// Package of constants and codes for the nonuniform table interpolator.
package nti_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = 8;
	localparam int DATA_W      = 32;
	localparam int NPTS_W      = 9;
	localparam int PROD_W      = 128;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic CFG_NUM_POINTS   = 1'b0;
	localparam logic CFG_INTERP_ORDER = 1'b1;

	localparam logic [1:0] ORD_LINEAR = 2'd0;
	localparam logic [1:0] ORD_QUAD   = 2'd1;
	localparam logic [1:0] ORD_CUBIC  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_ZERO = 2'd2,
		ST_SAT  = 2'd3
	} status_t;
endpackage

@@ rtl/nonuniform_table_interpolator.sv @@
// Top level of the nonuniform table interpolator: table store, search and Lagrange unit.
//
// Input channel (in_valid/in_ready) carries one word per item. cmd write stores
// entry_x/entry_y at entry_index on acceptance and returns nothing. cmd query
// locates query_x in the first num_points entries by bisection, picks a stencil
// of 2, 3 or 4 entries after interp_order and returns one output word with the
// Q16.16 value, the stencil start and a status code. Configuration (cfg_we,
// cfg_index, cfg_data) is written by the user only while idle, unchecked by the block.
// Each table read goes through the registered read port, one read per bisection
// step. Each Lagrange term then runs its factors through a shared 33-step
// shift-add multiplier and one 128-step restoring divider.
// One query is handled at a time; in_ready is low from acceptance until the
// result is moved to the output register.
// Reset clears the sequencer and out_valid, sets num_points to 2 and
// interp_order to linear; the table holds whatever it held until written.
// A stalled receiver holds the output word; a finished query waits for the
// register to free, and no input word is taken meanwhile.
module nonuniform_table_interpolator
	import nti_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [NPTS_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic [ADDR_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0] entry_x,
	input  logic signed [DATA_W-1:0] entry_y,
	input  logic signed [DATA_W-1:0] query_x,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] interp_value,
	output logic [ADDR_W-1:0]        left_index,
	output logic [1:0]               status
);

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_X0, S_XN, S_BIS, S_BUSE, S_LEFT, S_QA, S_QB,
		S_LOAD, S_LUSE, S_ZCHK, S_TINIT, S_FAC, S_MUL, S_DIV, S_ACC,
		S_FIN, S_EMIT
	} state_t;

	localparam logic [60:0] TERM_LIMIT = 61'd1 << 60;
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	state_t state_q, ret_q;

	logic [NPTS_W-1:0] num_points_q;
	logic [1:0]        order_q;

	// Table store, registered read port.
	logic [DATA_W-1:0] xmem_q [TABLE_DEPTH];
	logic [DATA_W-1:0] ymem_q [TABLE_DEPTH];
	logic [ADDR_W-1:0] addr_q;
	logic signed [DATA_W-1:0] rdx_q, rdy_q;

	// Query context.
	logic signed [DATA_W-1:0] q_q, x0_q, xn_q, xi_q;
	logic [NPTS_W-1:0] n_q, lo_q, hi_q, i_q;
	logic [1:0]        ord_q;
	logic [2:0]        size_q;
	logic              asc_q;
	logic [ADDR_W-1:0] left_q;
	logic signed [DATA_W-1:0] sx_q [4];
	logic signed [DATA_W-1:0] sy_q [4];

	// Shared arithmetic unit state.
	logic [2:0]        k_q, a_q;
	logic [PROD_W-1:0] num_q, den_q, p_q, rem_q, quo_q;
	logic [32:0]       f_q;
	logic              den_sel_q, neg_q, sat_q;
	logic [5:0]        bit_q;
	logic [6:0]        cnt_q;
	logic signed [63:0] acc_q;

	// Result waiting for the output register.
	logic signed [DATA_W-1:0] res_val_q;
	logic [ADDR_W-1:0] res_left_q;
	logic [1:0]        res_stat_q;

	logic              out_valid_q;
	logic signed [DATA_W-1:0] out_val_q;
	logic [ADDR_W-1:0] out_left_q;
	logic [1:0]        out_stat_q;

	function automatic logic signed [32:0] diff33(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		return {a[DATA_W-1], a} - {b[DATA_W-1], b};
	endfunction

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign interp_value = out_val_q;
	assign left_index   = out_left_q;
	assign status       = out_stat_q;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// Query set-up from the registers.
	logic [NPTS_W-1:0] n_eff;
	logic [1:0]        ord_eff;
	logic [2:0]        size_eff;
	always_comb begin
		n_eff    = (num_points_q > NPTS_W'(TABLE_DEPTH)) ? NPTS_W'(TABLE_DEPTH) : num_points_q;
		ord_eff  = (order_q > ORD_CUBIC) ? ORD_CUBIC : order_q;
		size_eff = 3'(ord_eff) + 3'd2;
	end

	// Bisection midpoint.
	logic [NPTS_W:0] mid_sum;
	assign mid_sum = {1'b0, hi_q} + {1'b0, lo_q};

	// Stencil-start choice once the segment is known.
	logic [NPTS_W-1:0] n_m2, n_m3, n_m4;
	assign n_m2 = n_q - NPTS_W'(2);
	assign n_m3 = n_q - NPTS_W'(3);
	assign n_m4 = n_q - NPTS_W'(4);

	// Equal breakpoints inside the stencil.
	logic zero_hit;
	always_comb begin
		zero_hit = (sx_q[0] == sx_q[1]);
		if (size_q > 3'd2)
			zero_hit = zero_hit || (sx_q[0] == sx_q[2]) || (sx_q[1] == sx_q[2]);
		if (size_q > 3'd3)
			zero_hit = zero_hit || (sx_q[0] == sx_q[3]) || (sx_q[1] == sx_q[3])
				|| (sx_q[2] == sx_q[3]);
	end

	// Factor of the current term: numerator factors first, then denominator ones.
	logic [2:0] nn, ntot, nterms, jj;
	logic [1:0] bsel, asel;
	logic signed [32:0] fac;
	logic fac_den;
	always_comb begin
		asel    = a_q[1:0];
		jj      = k_q - size_q;
		bsel    = 2'd0;
		fac     = '0;
		fac_den = 1'b0;
		if (ord_q == ORD_LINEAR) begin
			nn     = 3'd2;
			ntot   = 3'd3;
			nterms = 3'd1;
			case (k_q)
				3'd0:    fac = diff33(sy_q[1], sy_q[0]);
				3'd1:    fac = diff33(q_q, sx_q[0]);
				default: begin
					fac     = diff33(sx_q[1], sx_q[0]);
					fac_den = 1'b1;
				end
			endcase
		end else begin
			nn     = size_q;
			ntot   = 3'((size_q << 1) - 3'd1);
			nterms = size_q;
			if (k_q < size_q - 3'd1) begin
				bsel = k_q[1:0] + ((k_q[1:0] >= asel) ? 2'd1 : 2'd0);
				fac  = diff33(q_q, sx_q[bsel]);
			end else if (k_q == size_q - 3'd1) begin
				fac = {sy_q[asel][DATA_W-1], sy_q[asel]};
			end else begin
				bsel    = jj[1:0] + ((jj[1:0] >= asel) ? 2'd1 : 2'd0);
				fac     = diff33(sx_q[asel], sx_q[bsel]);
				fac_den = 1'b1;
			end
		end
	end

	// Shared shift-add multiplier step and restoring divider step.
	logic [PROD_W-1:0] mul_next, rem_sh;
	logic              div_ge;
	always_comb begin
		mul_next = {p_q[PROD_W-2:0], 1'b0}
			+ (f_q[bit_q] ? (den_sel_q ? den_q : num_q) : '0);
		rem_sh   = {rem_q[PROD_W-2:0], num_q[PROD_W-1]};
		div_ge   = (rem_sh >= den_q);
	end

	// Term clamp and signed accumulate.
	logic [60:0]        term_mag;
	logic               term_sat;
	logic signed [63:0] term_val;
	always_comb begin
		term_sat = (quo_q > PROD_W'(TERM_LIMIT));
		term_mag = term_sat ? TERM_LIMIT : quo_q[60:0];
		term_val = neg_q ? -$signed({3'b000, term_mag}) : $signed({3'b000, term_mag});
	end

	// Quadratic nearest-side test.
	logic quad_left;
	assign quad_left = abs33(diff33(q_q, xi_q)) < abs33(diff33(rdx_q, q_q));

	// Table write and registered read.
	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_WRITE) begin
			xmem_q[entry_index] <= entry_x;
			ymem_q[entry_index] <= entry_y;
		end
		rdx_q <= xmem_q[addr_q];
		rdy_q <= ymem_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			out_valid_q  <= 1'b0;
			num_points_q <= NPTS_W'(2);
			order_q      <= ORD_LINEAR;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NUM_POINTS:   num_points_q <= cfg_data;
					CFG_INTERP_ORDER: order_q      <= cfg_data[1:0];
					default: ;
				endcase
			end
			// Drop the output word once taken, unless a new one replaces it.
			if (out_valid_q && out_ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && cmd == CMD_QUERY) begin
						q_q    <= query_x;
						n_q    <= n_eff;
						ord_q  <= ord_eff;
						size_q <= size_eff;
						if (n_eff < NPTS_W'(size_eff)) begin
							res_val_q  <= '0;
							res_left_q <= '0;
							res_stat_q <= ST_FEW;
							state_q    <= S_EMIT;
						end else begin
							addr_q  <= '0;
							ret_q   <= S_X0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= ret_q;
				S_X0: begin
					x0_q    <= rdx_q;
					addr_q  <= ADDR_W'(n_q - NPTS_W'(1));
					ret_q   <= S_XN;
					state_q <= S_RD;
				end
				S_XN: begin
					xn_q    <= rdx_q;
					asc_q   <= (rdx_q >= x0_q);
					lo_q    <= '0;
					hi_q    <= n_q;
					state_q <= S_BIS;
				end
				S_BIS: begin
					if (hi_q - lo_q > NPTS_W'(1)) begin
						addr_q  <= mid_sum[ADDR_W:1];
						ret_q   <= S_BUSE;
						state_q <= S_RD;
					end else begin
						// Exact hits on the end points win over the search.
						if (q_q == x0_q)
							i_q <= '0;
						else if (q_q == xn_q)
							i_q <= n_q - NPTS_W'(1);
						else
							i_q <= lo_q;
						state_q <= S_LEFT;
					end
				end
				S_BUSE: begin
					if ((q_q >= rdx_q) == asc_q)
						lo_q <= {1'b0, addr_q};
					else
						hi_q <= {1'b0, addr_q};
					state_q <= S_BIS;
				end
				S_LEFT: begin
					k_q     <= '0;
					state_q <= S_LOAD;
					unique case (ord_q)
						ORD_LINEAR: left_q <= ADDR_W'((i_q > n_m2) ? n_m2 : i_q);
						ORD_QUAD: begin
							if (i_q == '0)
								left_q <= '0;
							else if (i_q > n_m3)
								left_q <= ADDR_W'(n_m3);
							else begin
								addr_q  <= ADDR_W'(i_q);
								ret_q   <= S_QA;
								state_q <= S_RD;
							end
						end
						default: begin
							if (i_q == '0)
								left_q <= '0;
							else if (i_q > n_m3)
								left_q <= ADDR_W'(n_m4);
							else
								left_q <= ADDR_W'(i_q - NPTS_W'(1));
						end
					endcase
				end
				S_QA: begin
					xi_q    <= rdx_q;
					addr_q  <= ADDR_W'(i_q + NPTS_W'(1));
					ret_q   <= S_QB;
					state_q <= S_RD;
				end
				S_QB: begin
					left_q  <= quad_left ? ADDR_W'(i_q - NPTS_W'(1)) : ADDR_W'(i_q);
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					addr_q  <= left_q + ADDR_W'(k_q[1:0]);
					ret_q   <= S_LUSE;
					state_q <= S_RD;
				end
				S_LUSE: begin
					sx_q[k_q[1:0]] <= rdx_q;
					sy_q[k_q[1:0]] <= rdy_q;
					k_q            <= k_q + 3'd1;
					state_q        <= (k_q == size_q - 3'd1) ? S_ZCHK : S_LOAD;
				end
				S_ZCHK: begin
					if (zero_hit) begin
						res_val_q  <= '0;
						res_left_q <= left_q;
						res_stat_q <= ST_ZERO;
						state_q    <= S_EMIT;
					end else begin
						a_q     <= '0;
						sat_q   <= 1'b0;
						acc_q   <= (ord_q == ORD_LINEAR) ? 64'(sy_q[0]) : '0;
						state_q <= S_TINIT;
					end
				end
				S_TINIT: begin
					num_q   <= PROD_W'(1);
					den_q   <= PROD_W'(1);
					neg_q   <= 1'b0;
					k_q     <= '0;
					state_q <= S_FAC;
				end
				S_FAC: begin
					f_q       <= abs33(fac);
					neg_q     <= neg_q ^ fac[32];
					den_sel_q <= fac_den;
					p_q       <= '0;
					bit_q     <= 6'd32;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					p_q   <= mul_next;
					bit_q <= bit_q - 6'd1;
					if (bit_q == '0) begin
						if (den_sel_q)
							den_q <= mul_next;
						else
							num_q <= mul_next;
						k_q <= k_q + 3'd1;
						if (k_q + 3'd1 == ntot) begin
							rem_q   <= '0;
							quo_q   <= '0;
							cnt_q   <= 7'(PROD_W - 1);
							state_q <= S_DIV;
						end else
							state_q <= S_FAC;
					end
				end
				S_DIV: begin
					num_q <= {num_q[PROD_W-2:0], 1'b0};
					rem_q <= div_ge ? rem_sh - den_q : rem_sh;
					quo_q <= {quo_q[PROD_W-2:0], div_ge};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0)
						state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + term_val;
					sat_q <= sat_q | term_sat;
					a_q   <= a_q + 3'd1;
					state_q <= (a_q + 3'd1 == nterms) ? S_FIN : S_TINIT;
				end
				S_FIN: begin
					res_left_q <= left_q;
					if (acc_q > SMAX) begin
						res_val_q  <= DATA_W'(SMAX);
						res_stat_q <= ST_SAT;
					end else if (acc_q < SMIN) begin
						res_val_q  <= DATA_W'(SMIN);
						res_stat_q <= ST_SAT;
					end else begin
						res_val_q  <= DATA_W'(acc_q);
						res_stat_q <= sat_q ? ST_SAT : ST_OK;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Hold until the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val_q;
						out_left_q  <= res_left_q;
						out_stat_q  <= res_stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// nn is the numerator factor count; every factor beyond it is a denominator one.
	logic nn_ok;
	assign nn_ok = (k_q < nn) != fac_den;

	`include "nonuniform_table_interpolator_macros.svh"

	`NTI_ASSERT_NOW(a_few_zero, out_valid && status == ST_FEW, interp_value == '0 && left_index == '0, "few")
	`NTI_ASSERT_NOW(a_zero_val, out_valid && status == ST_ZERO, interp_value == '0, "zero den")
	`NTI_ASSERT_NEXT(a_busy, in_valid && in_ready && cmd == CMD_QUERY, !in_ready, "busy")
	`NTI_ASSERT_NOW(a_bis, state_q == S_BIS || state_q == S_BUSE, hi_q > lo_q, "bounds")
	`NTI_ASSERT_NOW(a_fac, state_q == S_FAC, nn_ok, "factor kind")

endmodule
